// ===== rtl/torque_table_setpoint_stepper_unit_macros.svh =====
// Assertion macros shared by the checker of the torque table setpoint stepper.
`ifndef TORQUE_TABLE_SETPOINT_STEPPER_UNIT_MACROS_SVH
`define TORQUE_TABLE_SETPOINT_STEPPER_UNIT_MACROS_SVH

// Next-cycle implication, masked while reset is high.
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Same-cycle implication, masked while reset is high.
`define TTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define TTS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tts_pkg.sv =====
// Shared types and constants of the torque table setpoint stepper.
`timescale 1ns / 1ps
package tts_pkg;

  localparam int OMEGA_POINTS_DEF = 16;
  localparam int WIND_POINTS_DEF  = 16;
  localparam int VALUE_BITS_DEF   = 16;

  localparam int KIND_BITS      = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 15;
  localparam int STEP_BITS      = 15;
  localparam int COUNT_BITS     = 5;

  localparam logic [STEP_BITS-1:0]  STEP_SIZE_RESET   = 15'd51;
  localparam logic [COUNT_BITS-1:0] POINTS_USED_RESET = 5'd16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_SIZE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_OMEGA_USED = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WIND_USED  = 2'd2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LOAD_OMEGA  = 2'd0,
    KIND_LOAD_WIND   = 2'd1,
    KIND_LOAD_TORQUE = 2'd2,
    KIND_STEP        = 2'd3
  } kind_t;

  // Control of one breakpoint ring: load one cell, or rotate all by one place.
  typedef struct packed {
    logic load;
    logic shift;
  } ring_ctrl_t;

endpackage

// ===== rtl/torque_table_setpoint_stepper_unit.sv =====
// Top level of the torque table setpoint stepper: control, torque table and setpoint update.
`timescale 1ns / 1ps
// A load item (kind 0, 1 or 2) writes one omega breakpoint, wind breakpoint or torque table
// entry and gives no result. A step item (kind 3) gives exactly one result: the setpoint
// after the step and a matched flag; with no wind column equal to the wind speed or no omega
// interval holding the speed, the setpoint is returned unchanged with matched low.
// The breakpoints sit in two rings of cells that rotate past a compare head, so a step scans
// both rings, then reads two torque entries from the table memory, multiplies and updates
// the setpoint when a column and an interval are found; when either is missing, the second
// table read and the multiply are skipped. The next item waits until the step is done,
// and longer while a previous result is not taken.
// Configuration registers are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
module torque_table_setpoint_stepper_unit #(
  parameter int OMEGA_POINTS = tts_pkg::OMEGA_POINTS_DEF,
  parameter int WIND_POINTS  = tts_pkg::WIND_POINTS_DEF,
  parameter int VALUE_BITS   = tts_pkg::VALUE_BITS_DEF,
  localparam int ROW_BITS      = $clog2(OMEGA_POINTS),
  localparam int COL_BITS      = (WIND_POINTS > 1) ? $clog2(WIND_POINTS) : 1,
  localparam int IN_FIELD_BITS = ROW_BITS + COL_BITS + 4 * VALUE_BITS,
  localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_BITS = ((VALUE_BITS + 7) / 8) * 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [tts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // row_index, column_index, load_value, measured_torque, measured_omega, wind_speed
  input  logic [IN_DATA_BITS-1:0]            s_tdata,
  // kind
  input  logic [tts_pkg::KIND_BITS-1:0]      s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // setpoint
  output logic [OUT_DATA_BITS-1:0]           m_tdata,
  // matched
  output logic [0:0]                         m_tuser
);

  localparam int MAX_POINTS = (OMEGA_POINTS > WIND_POINTS) ? OMEGA_POINTS : WIND_POINTS;
  localparam int CNT_BITS   = ($clog2(MAX_POINTS + 1) > tts_pkg::COUNT_BITS) ?
                              $clog2(MAX_POINTS + 1) : tts_pkg::COUNT_BITS;
  localparam int ADDR_BITS  = $clog2(OMEGA_POINTS * WIND_POINTS);
  localparam int SUM_BITS   = ((VALUE_BITS > tts_pkg::STEP_BITS) ?
                              VALUE_BITS : tts_pkg::STEP_BITS + 1) + 1;
  localparam int COL_LSB    = ROW_BITS;
  localparam int LOAD_LSB   = ROW_BITS + COL_BITS;
  localparam int TORQUE_LSB = LOAD_LSB + VALUE_BITS;
  localparam int OMEGA_LSB  = TORQUE_LSB + VALUE_BITS;
  localparam int WIND_LSB   = OMEGA_LSB + VALUE_BITS;

  localparam logic signed [SUM_BITS-1:0] SP_HI =
    {{(SUM_BITS - VALUE_BITS + 1){1'b0}}, {(VALUE_BITS - 1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0] SP_LO =
    {{(SUM_BITS - VALUE_BITS + 1){1'b1}}, {(VALUE_BITS - 1){1'b0}}};

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_READ1 = 6'b000100,
    ST_READ2 = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_CMP   = 6'b100000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [tts_pkg::STEP_BITS-1:0]  step_size;
  logic [tts_pkg::COUNT_BITS-1:0] omega_used;
  logic [tts_pkg::COUNT_BITS-1:0] wind_used;

  // Input field unpacking.
  tts_pkg::kind_t               in_kind;
  logic [ROW_BITS-1:0]          in_row;
  logic [COL_BITS-1:0]          in_col;
  logic [VALUE_BITS-1:0]        in_load;
  logic                         in_accept;

  assign in_kind   = tts_pkg::kind_t'(s_tuser);
  assign in_row    = s_tdata[0 +: ROW_BITS];
  assign in_col    = s_tdata[COL_LSB +: COL_BITS];
  assign in_load   = s_tdata[LOAD_LSB +: VALUE_BITS];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;

  // Step operands.
  logic signed [VALUE_BITS-1:0] torque_q;
  logic signed [VALUE_BITS-1:0] omega_q;
  logic signed [VALUE_BITS-1:0] wind_q;

  // Breakpoint rings.
  tts_pkg::ring_ctrl_t   omega_ctrl;
  tts_pkg::ring_ctrl_t   wind_ctrl;
  logic [VALUE_BITS-1:0] omega_head;
  logic [VALUE_BITS-1:0] omega_head_next;
  logic [VALUE_BITS-1:0] wind_head;
  logic [VALUE_BITS-1:0] wind_head_next;
  logic [CNT_BITS-1:0]   cnt;

  assign omega_ctrl.load  = in_accept && (in_kind == tts_pkg::KIND_LOAD_OMEGA);
  assign omega_ctrl.shift = (state == ST_SCAN) && (cnt < CNT_BITS'(OMEGA_POINTS));
  assign wind_ctrl.load   = in_accept && (in_kind == tts_pkg::KIND_LOAD_WIND);
  assign wind_ctrl.shift  = (state == ST_SCAN) && (cnt < CNT_BITS'(WIND_POINTS));

  tts_ring #(
    .DEPTH     (OMEGA_POINTS),
    .VALUE_BITS(VALUE_BITS),
    .IDX_BITS  (ROW_BITS)
  ) u_omega_ring (
    .clk       (clk),
    .ctrl      (omega_ctrl),
    .load_index(in_row),
    .load_value(in_load),
    .head      (omega_head),
    .head_next (omega_head_next)
  );

  tts_ring #(
    .DEPTH     (WIND_POINTS),
    .VALUE_BITS(VALUE_BITS),
    .IDX_BITS  (COL_BITS)
  ) u_wind_ring (
    .clk       (clk),
    .ctrl      (wind_ctrl),
    .load_index(in_col),
    .load_value(in_load),
    .head      (wind_head),
    .head_next (wind_head_next)
  );

  // Point counts limited to the ring sizes.
  logic [CNT_BITS-1:0] omega_count;
  logic [CNT_BITS-1:0] wind_count;
  logic [CNT_BITS-1:0] cnt_plus;
  logic                wind_hit;
  logic                omega_hit;

  assign omega_count = (CNT_BITS'(omega_used) > CNT_BITS'(OMEGA_POINTS)) ?
                       CNT_BITS'(OMEGA_POINTS) : CNT_BITS'(omega_used);
  assign wind_count  = (CNT_BITS'(wind_used) > CNT_BITS'(WIND_POINTS)) ?
                       CNT_BITS'(WIND_POINTS) : CNT_BITS'(wind_used);
  assign cnt_plus    = cnt + CNT_BITS'(1);
  assign wind_hit    = (cnt < wind_count) && ($signed(wind_head) == wind_q);
  assign omega_hit   = (cnt_plus < omega_count) && ($signed(omega_head) <= omega_q) &&
                       (omega_q <= $signed(omega_head_next));

  // Scan results.
  logic                         found_w;
  logic                         found_o;
  logic [COL_BITS-1:0]          w_idx;
  logic [ROW_BITS-1:0]          o_idx;
  logic signed [VALUE_BITS-1:0] x1;
  logic signed [VALUE_BITS-1:0] x2;
  logic                         matched;

  // Torque table memory.
  logic [VALUE_BITS-1:0] table_mem [OMEGA_POINTS * WIND_POINTS];
  logic [ADDR_BITS-1:0]  wr_addr;
  logic                  wr_en;
  logic [ADDR_BITS-1:0]  addr1;
  logic [ADDR_BITS-1:0]  rd_addr;
  logic [VALUE_BITS-1:0] rd_data;

  assign wr_addr = ADDR_BITS'(ADDR_BITS'(in_row) * ADDR_BITS'(WIND_POINTS) + ADDR_BITS'(in_col));
  assign wr_en   = in_accept && (in_kind == tts_pkg::KIND_LOAD_TORQUE) &&
                   ({1'b0, in_row} < (ROW_BITS + 1)'(OMEGA_POINTS)) &&
                   ({1'b0, in_col} < (COL_BITS + 1)'(WIND_POINTS));
  assign addr1   = ADDR_BITS'(ADDR_BITS'(o_idx) * ADDR_BITS'(WIND_POINTS) + ADDR_BITS'(w_idx));
  assign rd_addr = (state == ST_READ1) ? addr1 : ADDR_BITS'(addr1 + ADDR_BITS'(WIND_POINTS));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= in_load;
    end
    rd_data <= table_mem[rd_addr];
  end

  // Interpolation compare by cross-multiplication.
  logic signed [VALUE_BITS-1:0]   y1;
  logic signed [VALUE_BITS:0]     diff_a;
  logic signed [VALUE_BITS:0]     diff_b;
  logic signed [VALUE_BITS:0]     diff_c;
  logic signed [VALUE_BITS:0]     diff_d;
  logic signed [2*VALUE_BITS+1:0] prod_l;
  logic signed [2*VALUE_BITS+1:0] prod_r;
  logic                           flat;
  logic                           torque_lt_y1;
  logic                           below;

  assign diff_a = (VALUE_BITS + 1)'(torque_q) - (VALUE_BITS + 1)'(y1);
  assign diff_b = (VALUE_BITS + 1)'($signed(rd_data)) - (VALUE_BITS + 1)'(y1);
  assign diff_c = (VALUE_BITS + 1)'(omega_q) - (VALUE_BITS + 1)'(x1);
  assign diff_d = (VALUE_BITS + 1)'(x2) - (VALUE_BITS + 1)'(x1);
  // A zero-width interval takes the lower table entry as the target.
  assign below  = flat ? torque_lt_y1 : (prod_l < prod_r);

  // Setpoint update with saturation.
  logic signed [VALUE_BITS-1:0] setpoint;
  logic signed [VALUE_BITS-1:0] setpoint_next;
  logic signed [SUM_BITS-1:0]   sp_ext;
  logic signed [SUM_BITS-1:0]   step_ext;
  logic signed [SUM_BITS-1:0]   sum;

  assign sp_ext   = SUM_BITS'(setpoint);
  assign step_ext = $signed(SUM_BITS'(step_size));
  assign sum      = below ? (sp_ext + step_ext) : (sp_ext - step_ext);

  always_comb begin
    if (!matched) begin
      setpoint_next = setpoint;
    end else if (sum > SP_HI) begin
      setpoint_next = VALUE_BITS'(SP_HI);
    end else if (sum < SP_LO) begin
      setpoint_next = VALUE_BITS'(SP_LO);
    end else begin
      setpoint_next = VALUE_BITS'(sum);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      step_size  <= tts_pkg::STEP_SIZE_RESET;
      omega_used <= tts_pkg::POINTS_USED_RESET;
      wind_used  <= tts_pkg::POINTS_USED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tts_pkg::CFG_STEP_SIZE:  step_size  <= cfg_data[tts_pkg::STEP_BITS-1:0];
        tts_pkg::CFG_OMEGA_USED: omega_used <= cfg_data[tts_pkg::COUNT_BITS-1:0];
        tts_pkg::CFG_WIND_USED:  wind_used  <= cfg_data[tts_pkg::COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      found_w  <= 1'b0;
      found_o  <= 1'b0;
      matched  <= 1'b0;
      setpoint <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if ((state == ST_CMP) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && (in_kind == tts_pkg::KIND_STEP)) begin
            torque_q <= $signed(s_tdata[TORQUE_LSB +: VALUE_BITS]);
            omega_q  <= $signed(s_tdata[OMEGA_LSB +: VALUE_BITS]);
            wind_q   <= $signed(s_tdata[WIND_LSB +: VALUE_BITS]);
            cnt      <= '0;
            found_w  <= 1'b0;
            found_o  <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Only the first hit in each ring counts.
          if (wind_hit && !found_w) begin
            found_w <= 1'b1;
            w_idx   <= cnt[COL_BITS-1:0];
          end
          if (omega_hit && !found_o) begin
            found_o <= 1'b1;
            o_idx   <= cnt[ROW_BITS-1:0];
            x1      <= $signed(omega_head);
            x2      <= $signed(omega_head_next);
          end
          cnt <= cnt_plus;
          if (cnt == CNT_BITS'(MAX_POINTS - 1)) begin
            state <= ST_READ1;
          end
        end
        ST_READ1: begin
          matched <= found_w && found_o;
          state   <= (found_w && found_o) ? ST_READ2 : ST_CMP;
        end
        ST_READ2: begin
          y1    <= $signed(rd_data);
          state <= ST_MUL;
        end
        ST_MUL: begin
          prod_l       <= diff_a * diff_d;
          prod_r       <= diff_b * diff_c;
          flat         <= (x2 == x1);
          torque_lt_y1 <= (torque_q < y1);
          state        <= ST_CMP;
        end
        ST_CMP: begin
          if (!m_tvalid || m_tready) begin
            setpoint <= setpoint_next;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_CMP) && (!m_tvalid || m_tready)) begin
      m_tdata <= OUT_DATA_BITS'($unsigned(setpoint_next));
      m_tuser <= matched;
    end
  end

endmodule

// ===== rtl/tts_cell.sv =====
// One breakpoint cell: holds a value, loads it when selected, takes its neighbor's on a shift.
`timescale 1ns / 1ps
module tts_cell #(
  parameter int VALUE_BITS = tts_pkg::VALUE_BITS_DEF
) (
  input  logic                   clk,
  input  tts_pkg::ring_ctrl_t    ctrl,
  input  logic                   sel,
  input  logic [VALUE_BITS-1:0]  load_value,
  input  logic [VALUE_BITS-1:0]  from_next,
  output logic [VALUE_BITS-1:0]  value
);

  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      value <= load_value;
    end else if (ctrl.shift) begin
      value <= from_next;
    end
  end

endmodule

// ===== rtl/tts_ring.sv =====
// Ring of breakpoint cells that rotates one place per shift; cell 0 is the head.
`timescale 1ns / 1ps
module tts_ring #(
  parameter int DEPTH      = tts_pkg::OMEGA_POINTS_DEF,
  parameter int VALUE_BITS = tts_pkg::VALUE_BITS_DEF,
  parameter int IDX_BITS   = 4
) (
  input  logic                   clk,
  input  tts_pkg::ring_ctrl_t    ctrl,
  input  logic [IDX_BITS-1:0]    load_index,
  input  logic [VALUE_BITS-1:0]  load_value,
  output logic [VALUE_BITS-1:0]  head,
  output logic [VALUE_BITS-1:0]  head_next
);

  logic [VALUE_BITS-1:0] vals [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tts_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .sel       (load_index == IDX_BITS'(i)),
      .load_value(load_value),
      .from_next (vals[(i + 1) % DEPTH]),
      .value     (vals[i])
    );
  end

  assign head      = vals[0];
  assign head_next = vals[1 % DEPTH];

endmodule

// ===== rtl/tts_checker.sv =====
// Port-level checker for the torque table setpoint stepper, bound to the top level.
`timescale 1ns / 1ps
`include "torque_table_setpoint_stepper_unit_macros.svh"
module tts_checker #(
  parameter int OUT_DATA_BITS = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [tts_pkg::KIND_BITS-1:0] s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [OUT_DATA_BITS-1:0]      m_tdata,
  input logic [0:0]                    m_tuser
);

  // A result waiting on the output holds its value.
  `TTS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

  // Reset leaves no result pending.
  `TTS_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !m_tvalid, "result valid after reset")

  // A step item keeps the input closed while it is worked on.
  `TTS_ASSERT_NEXT(a_step_busy, s_tvalid && s_tready && (s_tuser == tts_pkg::KIND_STEP), !s_tready, "input open during a step")

  // A load item does not stall the input: it is ready again in the next cycle.
  `TTS_ASSERT_NEXT(a_load_quick, s_tvalid && s_tready && (s_tuser != tts_pkg::KIND_STEP), s_tready, "load item stalled the input")

  // A new result only comes out of a step in progress.
  `TTS_ASSERT_NOW(a_result_source, $rose(m_tvalid), !$past(s_tready), "result without a step")

endmodule

bind torque_table_setpoint_stepper_unit tts_checker #(
  .OUT_DATA_BITS(OUT_DATA_BITS)
) u_tts_checker (.*);

// ===== tb/tb_torque_table_setpoint_stepper_unit.sv =====
// Self-checking testbench for the torque table setpoint stepper: table loads, steps, saturation.
`timescale 1ns / 1ps
module tb_torque_table_setpoint_stepper_unit;

  localparam int NPTS           = 16;
  localparam int HOLD_OFF       = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 7;
  localparam int PHASE_ITEMS    = 36;

  typedef struct packed {
    logic [15:0] setpoint;
    logic        matched;
  } step_result_t;

  logic                               clk       = 1'b0;
  logic                               rst       = 1'b1;
  logic                               cfg_we    = 1'b0;
  logic [tts_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [tts_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                               s_tvalid  = 1'b0;
  logic                               s_tready;
  // row_index, column_index, load_value, measured_torque, measured_omega, wind_speed
  logic [71:0]                        s_tdata   = '0;
  // kind
  logic [tts_pkg::KIND_BITS-1:0]      s_tuser   = '0;
  logic                               m_tvalid;
  logic                               m_tready  = 1'b0;
  // setpoint
  logic [15:0]                        m_tdata;
  // matched
  logic [0:0]                         m_tuser;

  // Predictor state: breakpoints, torque map, setpoint and the configuration.
  logic signed [15:0]  omega_bp [NPTS];
  logic signed [15:0]  wind_bp [NPTS];
  logic signed [15:0]  torque_map [NPTS*NPTS];
  longint              setpoint_acc = 0;
  logic [tts_pkg::STEP_BITS-1:0]  step_reg       = tts_pkg::STEP_SIZE_RESET;
  logic [tts_pkg::COUNT_BITS-1:0] omega_used_reg = tts_pkg::POINTS_USED_RESET;
  logic [tts_pkg::COUNT_BITS-1:0] wind_used_reg  = tts_pkg::POINTS_USED_RESET;

  step_result_t expected_results[$];
  int mismatches    = 0;
  int rx_stall_left = 0;
  int quiet_cycles  = 0;
  bit tx_idle_on    = 1'b0;
  bit rx_idle_on    = 1'b0;

  torque_table_setpoint_stepper_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // Moves the setpoint for one step and returns the result the block should give.
  function automatic step_result_t advance_setpoint(logic signed [15:0] torque,
      logic signed [15:0] omega, logic signed [15:0] wind);
    int i, nw, no, w, o;
    bit hit_w, hit_o, below;
    longint x1, x2, y1, y2, span;
    step_result_t r;
    nw = (wind_used_reg < NPTS) ? int'(wind_used_reg) : NPTS;
    no = (omega_used_reg < NPTS) ? int'(omega_used_reg) : NPTS;
    hit_w = 1'b0;
    hit_o = 1'b0;
    w = 0;
    o = 0;
    for (i = 0; i < nw && !hit_w; i++)
      if (wind_bp[i] == wind) begin
        hit_w = 1'b1;
        w = i;
      end
    if (hit_w && no >= 2)
      for (i = 0; i + 1 < no && !hit_o; i++)
        if (omega_bp[i] <= omega && omega <= omega_bp[i+1]) begin
          hit_o = 1'b1;
          o = i;
        end
    if (hit_w && hit_o) begin
      x1 = omega_bp[o];
      x2 = omega_bp[o+1];
      y1 = torque_map[o*NPTS + w];
      y2 = torque_map[(o+1)*NPTS + w];
      span = x2 - x1;
      // Cross-multiplied compare against the line through both table points.
      if (span == 0)
        below = longint'(torque) < y1;
      else
        below = (longint'(torque) - y1) * span < (y2 - y1) * (longint'(omega) - x1);
      if (below)
        setpoint_acc = setpoint_acc + longint'(step_reg);
      else
        setpoint_acc = setpoint_acc - longint'(step_reg);
      if (setpoint_acc > 32767)
        setpoint_acc = 32767;
      if (setpoint_acc < -32768)
        setpoint_acc = -32768;
    end
    r.setpoint = setpoint_acc[15:0];
    r.matched  = hit_w && hit_o;
    return r;
  endfunction

  // Torque on the interpolation line of interval o in column w, plus an offset.
  function automatic logic signed [15:0] line_torque(int o, int w,
      logic signed [15:0] omega, int offset);
    longint x1, x2, y1, y2, t;
    x1 = omega_bp[o];
    x2 = omega_bp[o+1];
    y1 = torque_map[o*NPTS + w];
    y2 = torque_map[(o+1)*NPTS + w];
    t = (x2 == x1) ? y1 : y1 + (y2 - y1) * (longint'(omega) - x1) / (x2 - x1);
    t = t + offset;
    if (t > 32767)
      t = 32767;
    if (t < -32768)
      t = -32768;
    return t[15:0];
  endfunction

  task automatic send_item(tts_pkg::kind_t kind, logic [3:0] row, logic [3:0] col,
      logic signed [15:0] value, logic signed [15:0] torque,
      logic signed [15:0] omega, logic signed [15:0] wind);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {wind, omega, torque, value, col, row};
    do @(posedge clk); while (!s_tready);
    case (kind)
      tts_pkg::KIND_LOAD_OMEGA:  omega_bp[row] = value;
      tts_pkg::KIND_LOAD_WIND:   wind_bp[col] = value;
      tts_pkg::KIND_LOAD_TORQUE: torque_map[{row, col}] = value;
      default:                   expected_results.push_back(advance_setpoint(torque, omega, wind));
    endcase
  endtask

  task automatic load_entry(tts_pkg::kind_t kind, logic [3:0] row, logic [3:0] col,
      logic signed [15:0] value);
    send_item(kind, row, col, value, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic control_step(logic signed [15:0] torque, logic signed [15:0] omega,
      logic signed [15:0] wind);
    send_item(tts_pkg::KIND_STEP, 4'($urandom), 4'($urandom), 16'($urandom), torque, omega,
              wind);
  endtask

  // Stops sending and waits for every outstanding result, then for extra cycles.
  task automatic wait_results(int extra);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_config(logic [tts_pkg::STEP_BITS-1:0] step,
      logic [tts_pkg::COUNT_BITS-1:0] n_omega, logic [tts_pkg::COUNT_BITS-1:0] n_wind);
    cfg_we    <= 1'b1;
    cfg_index <= tts_pkg::CFG_STEP_SIZE;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= tts_pkg::CFG_OMEGA_USED;
    cfg_data  <= {{(tts_pkg::CFG_DATA_BITS - tts_pkg::COUNT_BITS){1'b0}}, n_omega};
    @(posedge clk);
    cfg_index <= tts_pkg::CFG_WIND_USED;
    cfg_data  <= {{(tts_pkg::CFG_DATA_BITS - tts_pkg::COUNT_BITS){1'b0}}, n_wind};
    @(posedge clk);
    cfg_we <= 1'b0;
    step_reg       = step;
    omega_used_reg = n_omega;
    wind_used_reg  = n_wind;
  endtask

  // Every entry is written before the first step, so no step reads an unwritten entry.
  task automatic test_table_fill();
    int i, v;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    for (i = 0; i < NPTS; i++)
      load_entry(tts_pkg::KIND_LOAD_OMEGA, 4'(i), 4'd0, 16'(i * 4369 - 32768));
    for (i = 0; i < NPTS; i++) begin
      v = (i == 0) ? -32768 : (i == NPTS - 1) ? 32767 : (i - 8) * 100;
      load_entry(tts_pkg::KIND_LOAD_WIND, 4'd0, 4'(i), 16'(v));
    end
    for (i = 0; i < NPTS * NPTS; i++)
      load_entry(tts_pkg::KIND_LOAD_TORQUE, 4'(i / NPTS), 4'(i % NPTS), 16'($urandom));
  endtask

  task automatic test_directed_cases();
    control_step(-32768, -32768, -32768);
    control_step(32767, 32767, 32767);
    control_step(0, 0, 1);
    // At the left end of an interval the target is the first table point exactly.
    load_entry(tts_pkg::KIND_LOAD_TORQUE, 2, 8, 1000);
    load_entry(tts_pkg::KIND_LOAD_TORQUE, 3, 8, -1000);
    control_step(1000, omega_bp[2], wind_bp[8]);
    control_step(999, omega_bp[2], wind_bp[8]);
    control_step(0, 16'(omega_bp[2] + 2184), wind_bp[8]);
    // Two equal breakpoints make the first interval zero wide.
    load_entry(tts_pkg::KIND_LOAD_OMEGA, 1, 0, -32768);
    load_entry(tts_pkg::KIND_LOAD_TORQUE, 0, 8, 500);
    control_step(500, -32768, wind_bp[8]);
    control_step(499, -32768, wind_bp[8]);
    load_entry(tts_pkg::KIND_LOAD_OMEGA, 1, 0, -32768 + 4369);
    // A repeated wind value selects the first column that holds it.
    load_entry(tts_pkg::KIND_LOAD_WIND, 0, 12, wind_bp[3]);
    control_step(0, 0, wind_bp[3]);
    load_entry(tts_pkg::KIND_LOAD_WIND, 0, 12, 400);
    // Full-scale table points: the products of the compare reach their largest size.
    load_entry(tts_pkg::KIND_LOAD_TORQUE, 15, 15, 32767);
    load_entry(tts_pkg::KIND_LOAD_TORQUE, 14, 15, -32768);
    control_step(32767, 32767, 32767);
    control_step(32766, 32767, 32767);
    control_step(-32768, omega_bp[14], 32767);
  endtask

  task automatic test_saturation();
    wait_results(HOLD_OFF);
    set_config(15'h7FFF, 16, 16);
    load_entry(tts_pkg::KIND_LOAD_TORQUE, 1, 1, 0);
    repeat (3) control_step(-32768, omega_bp[1], wind_bp[1]);
    repeat (4) control_step(32767, omega_bp[1], wind_bp[1]);
    wait_results(HOLD_OFF);
    set_config(0, 16, 16);
    control_step(-32768, omega_bp[1], wind_bp[1]);
    control_step(32767, omega_bp[1], wind_bp[1]);
  endtask

  // Point counts of zero, one, the minimum and past the table size.
  task automatic test_point_counts();
    wait_results(HOLD_OFF);
    set_config(51, 0, 16);
    control_step(0, 0, wind_bp[0]);
    wait_results(HOLD_OFF);
    set_config(51, 1, 16);
    control_step(0, omega_bp[0], wind_bp[0]);
    wait_results(HOLD_OFF);
    set_config(51, 2, 0);
    control_step(0, omega_bp[0], wind_bp[0]);
    wait_results(HOLD_OFF);
    set_config(51, 2, 1);
    control_step(0, 16'(omega_bp[0] + 100), wind_bp[0]);
    control_step(0, 0, wind_bp[0]);
    control_step(0, 16'(omega_bp[0] + 100), wind_bp[1]);
    wait_results(HOLD_OFF);
    set_config(51, 31, 31);
    control_step(0, 32767, 32767);
    control_step(0, omega_bp[7], wind_bp[9]);
    wait_results(HOLD_OFF);
    set_config(51, 17, 24);
    control_step(-5, 32767, 32767);
  endtask

  task automatic test_random_phases();
    int ph, n, i, acc, nw, no, w, o, lo_v, hi_v;
    logic [tts_pkg::STEP_BITS-1:0] step;
    logic [tts_pkg::COUNT_BITS-1:0] n_omega, n_wind;
    logic signed [15:0] om, tq;
    for (ph = 0; ph < PHASES; ph++) begin
      wait_results(HOLD_OFF);
      case ($urandom_range(0, 4))
        0:       step = '0;
        1:       step = 15'h7FFF;
        2:       step = 15'($urandom_range(1, 64));
        default: step = 15'($urandom_range(0, 32767));
      endcase
      n_omega = 5'(($urandom_range(0, 3) != 0) ? $urandom_range(2, 16) : $urandom_range(0, 31));
      n_wind  = 5'(($urandom_range(0, 3) != 0) ? $urandom_range(1, 16) : $urandom_range(0, 31));
      set_config(step, n_omega, n_wind);
      // The last phase runs at full rate on both sides.
      tx_idle_on = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
      rx_idle_on = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);

      if ($urandom_range(0, 1)) begin
        // Ascending breakpoints, with an occasional repeat that makes a zero-wide interval.
        acc = -32768 + int'($urandom_range(0, 2000));
        for (i = 0; i < NPTS; i++) begin
          load_entry(tts_pkg::KIND_LOAD_OMEGA, 4'(i), 4'd0, 16'(acc));
          acc = acc + (($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 4000)));
          if (acc > 32767)
            acc = 32767;
        end
      end
      for (i = 0; i < 4; i++)
        load_entry(tts_pkg::KIND_LOAD_WIND, 4'd0, 4'($urandom_range(0, 15)),
                   $urandom_range(0, 1) ? 16'($urandom) : wind_bp[$urandom_range(0, 15)]);
      for (i = 0; i < 8; i++)
        load_entry(tts_pkg::KIND_LOAD_TORQUE, 4'($urandom_range(0, 15)),
                   4'($urandom_range(0, 15)), 16'($urandom));

      nw = (n_wind < NPTS) ? int'(n_wind) : NPTS;
      no = (n_omega < NPTS) ? int'(n_omega) : NPTS;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2)
          wait_results(0);
        case ($urandom_range(0, 9))
          0: load_entry(tts_pkg::kind_t'($urandom_range(0, 2)), 4'($urandom), 4'($urandom),
                        16'($urandom));
          1: control_step(16'($urandom), 16'($urandom), 16'($urandom));
          default: begin
            if (nw == 0 || no < 2) begin
              control_step(16'($urandom), 16'($urandom), wind_bp[$urandom_range(0, 15)]);
            end else begin
              w = int'($urandom_range(0, nw - 1));
              o = int'($urandom_range(0, no - 2));
              lo_v = omega_bp[o];
              hi_v = omega_bp[o+1];
              if (lo_v > hi_v)
                om = 16'($urandom);
              else if ($urandom_range(0, 3) == 0)
                om = $urandom_range(0, 1) ? 16'(lo_v) : 16'(hi_v);
              else
                om = 16'(lo_v + int'($urandom_range(0, hi_v - lo_v)));
              if ($urandom_range(0, 3) == 0)
                tq = 16'($urandom);
              else
                tq = line_torque(o, w, om, int'($urandom_range(0, 4)) - 2);
              control_step(tq, om, wind_bp[w]);
            end
          end
        endcase
      end
    end
  endtask

  // Result checking and the receiver's ready, which stalls in random bursts.
  always @(posedge clk) begin : result_check
    step_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected item: expected none, actual setpoint %h matched %b",
                 $time, m_tdata, m_tuser);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (m_tdata !== want.setpoint) begin
          $display("%0t: setpoint mismatch: expected %h actual %h",
                   $time, want.setpoint, m_tdata);
          mismatches++;
        end
        if (m_tuser[0] !== want.matched) begin
          $display("%0t: matched mismatch: expected %b actual %b",
                   $time, want.matched, m_tuser[0]);
          mismatches++;
        end
      end
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      m_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(0, 7);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_torque_table_setpoint_stepper_unit: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_table_fill();
    test_directed_cases();
    test_saturation();
    test_point_counts();
    test_random_phases();
    wait_results(HOLD_OFF);
    if (mismatches == 0) begin
      $display("tb_torque_table_setpoint_stepper_unit: done, clean");
    end else begin
      $display("tb_torque_table_setpoint_stepper_unit: done, errors");
    end
    $finish;
  end

endmodule
